// File: hw/rtl/srpg_pkg.sv
// Package for the seeded rhythm pattern generator: constants, stage layout,
// the xorshift32 round and the per-row hit thresholds. No dependencies.
`default_nettype none

package srpg_pkg;

    localparam int unsigned PadW       = 6;
    localparam int unsigned RowW       = 3;
    localparam int unsigned GenW       = 32;
    localparam int unsigned StepCount  = 32;
    localparam int unsigned ThrW       = 25;
    localparam int unsigned InDataW    = 8;
    localparam int unsigned OutDataW   = 40;

    localparam logic [GenW-1:0] PadHashMul     = 32'd2654435761;
    localparam logic [GenW-1:0] FactoryKitSeed = 32'h6472_6d73;

    // Stage 0 mixes pad into seed, stage 1 warms up, stages 2..9 draw four
    // steps each, the last stage applies the no-hit fallback.
    localparam int unsigned RoundsPerStage = 4;
    localparam int unsigned FirstDraw      = 2;
    localparam int unsigned DrawStages     = StepCount / RoundsPerStage;
    localparam int unsigned StageCount     = FirstDraw + DrawStages + 1;
    localparam int unsigned LastStage      = StageCount - 1;

    function automatic logic [GenW-1:0] mix_round(input logic [GenW-1:0] v);
        logic [GenW-1:0] t;
        t = v ^ (v << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // Ceiling of density * factor * 2^24, off-beat and on-beat per row.
    function automatic logic [ThrW-1:0] hit_threshold(input logic [RowW-1:0] row,
                                                      input logic on_beat);
        logic [ThrW-1:0] off_thr;
        logic [ThrW-1:0] on_thr;
        unique case (row)
            3'd0: begin off_thr = 25'd12582912; on_thr = 25'd12582912; end
            3'd1: begin off_thr = 25'd9501382;  on_thr = 25'd15835638; end
            3'd2: begin off_thr = 25'd6847843;  on_thr = 25'd17804392; end
            3'd3: begin off_thr = 25'd4622294;  on_thr = 25'd18489176; end
            3'd4: begin off_thr = 25'd2824735;  on_thr = 25'd17889992; end
            3'd5: begin off_thr = 25'd1455167;  on_thr = 25'd16006834; end
            3'd6: begin off_thr = 25'd513589;   on_thr = 25'd12839707; end
            default: begin off_thr = 25'd0;     on_thr = 25'd8388608;  end
        endcase
        return on_beat ? on_thr : off_thr;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/seeded_rhythm_pattern_generator.sv
// Top level of the seeded rhythm pattern generator: an eleven-stage pipeline
// of xorshift32 rounds producing one pad's 32-step hit word. Uses srpg_pkg.
//
//  channel  | dir | payload (low bit up)                 | handshake
//  s_axis   | in  | pad_number[5:0], zero fill           | tvalid/tready
//  m_axis   | out | pad_echo[5:0], hit_pattern[37:6]     | tvalid/tready
//  cfg      | in  | kit_seed[31:0]                       | cfg_wr_en
//
// One item enters per cycle unless a stalled output backs up the pipeline;
// 36 rounds run four per stage (warm-up, draw), plus mix and fallback stages.
// Each stage holds its item until the next stage is free, so bubbles close
// up and a stalled output loses nothing. Reset (aresetn low, synchronous)
// empties the pipeline and reloads the factory seed.
`default_nettype none

module seeded_rhythm_pattern_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [31:0]                   cfg_wr_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [srpg_pkg::InDataW-1:0]  s_axis_tdata,  // [5:0] pad_number, [7:6] zero
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] pad_echo, [37:6] hit_pattern, [39:38] zero
    output logic [srpg_pkg::OutDataW-1:0]      m_axis_tdata
);

    localparam int unsigned NSt = srpg_pkg::StageCount;

    logic [srpg_pkg::GenW-1:0]      kit_seed_reg;
    logic [NSt-1:0]                 valid_reg;
    logic [srpg_pkg::PadW-1:0]      pad_reg  [NSt];
    logic [srpg_pkg::GenW-1:0]      gen_reg  [NSt];
    logic [srpg_pkg::StepCount-1:0] word_reg [NSt];
    logic [srpg_pkg::GenW-1:0]      gen_next [NSt];
    logic [srpg_pkg::StepCount-1:0] word_next[NSt];
    logic [NSt-1:0]                 stage_ready;
    logic [srpg_pkg::PadW-1:0]      in_pad;

    assign in_pad = s_axis_tdata[srpg_pkg::PadW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kit_seed_reg <= srpg_pkg::FactoryKitSeed;
        end else if (cfg_wr_en) begin
            kit_seed_reg <= cfg_wr_data;
        end
    end

    // A stage may load when it is empty or its item moves on this cycle.
    always_comb begin
        stage_ready[NSt-1] = !valid_reg[NSt-1] || m_axis_tready;
        for (int i = NSt - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb begin
        logic [srpg_pkg::GenW-1:0]      g;
        logic [srpg_pkg::StepCount-1:0] w;
        logic [srpg_pkg::RowW-1:0]      row;
        gen_next[0]  = kit_seed_reg
                     ^ 32'({26'd0, in_pad} * srpg_pkg::PadHashMul);
        word_next[0] = '0;
        for (int i = 1; i < NSt; i++) begin
            g   = gen_reg[i-1];
            w   = word_reg[i-1];
            row = pad_reg[i-1][srpg_pkg::PadW-1 -: srpg_pkg::RowW];
            if (i == 1) begin
                for (int r = 0; r < srpg_pkg::RoundsPerStage; r++) begin
                    g = srpg_pkg::mix_round(g);
                end
            end else if (i < srpg_pkg::LastStage) begin
                for (int r = 0; r < srpg_pkg::RoundsPerStage; r++) begin
                    g = srpg_pkg::mix_round(g);
                    // first round of each group of four is the on-beat step
                    if ({1'b0, g[31:8]} < srpg_pkg::hit_threshold(row, r == 0)) begin
                        w[(i - srpg_pkg::FirstDraw) * srpg_pkg::RoundsPerStage + r] = 1'b1;
                    end
                end
            end else begin
                if (w == '0) begin
                    w = srpg_pkg::StepCount'(1) << pad_reg[i-1][3:0];
                end
            end
            gen_next[i]  = g;
            word_next[i] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSt; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            pad_reg[0]  <= in_pad;
            gen_reg[0]  <= gen_next[0];
            word_reg[0] <= word_next[0];
        end
        for (int i = 1; i < NSt; i++) begin
            if (stage_ready[i]) begin
                pad_reg[i]  <= pad_reg[i-1];
                gen_reg[i]  <= gen_next[i];
                word_reg[i] <= word_next[i];
            end
        end
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[NSt-1];
    assign m_axis_tdata  = {2'b00, word_reg[NSt-1], pad_reg[NSt-1]};

endmodule

`default_nettype wire

// File: hw/rtl/srpg_checker.sv
// Port-level checker for seeded_rhythm_pattern_generator, bound to the top
// level below. Depends on the top level's port list only.
`default_nettype none

module srpg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // every delivered item carries at least one hit
    a_hit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[37:6] != 32'd0))
        else $error("srpg: empty hit pattern delivered");

    a_pad_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[39:38] == 2'b00))
        else $error("srpg: fill bits set");

    // output free means the whole pipeline can advance
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("srpg: input stalled with output free");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("srpg: stalled item changed");

endmodule

bind seeded_rhythm_pattern_generator srpg_checker u_srpg_checker (.*);

`default_nettype wire
